>>> rtl/dpllfm_pkg.sv
// Shared types and constants for the digital PLL frequency multiplier.
package dpllfm_pkg;

	localparam int TICK_W = 16;
	localparam int MULT_W = 8;
	localparam int IDX_W  = 8;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_MULTIPLIER = 8'd0;
	localparam logic [IDX_W-1:0] REG_MIN_PERIOD = 8'd1;

	localparam logic [MULT_W-1:0] MULT_RESET       = 8'd1;
	localparam logic [TICK_W-1:0] MIN_PERIOD_RESET = 16'd1000;

	// x / 10 == (x * 52429) >> 19 for every 16-bit x
	localparam int               RECIP_W     = 17;
	localparam logic [RECIP_W-1:0] RECIP_10  = 17'd52429;
	localparam int               RECIP_SHIFT = 19;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/digital_pll_frequency_multiplier.sv
// Digital PLL frequency multiplier: top level, tick sequencer and output register.
// One transaction on the input channel is one timer tick; each tick yields one result
// transaction. A tick without an accepted zero crossing goes via ST_APPLY to the
// result; a tick with an accepted crossing first waits in ST_DIV for the restoring
// divider that forms tick_count / (STEPS_PER_HALF * multiplier) one quotient bit per
// cycle. A new tick is taken while the previous result still waits in the output
// register. Configuration writes are accepted in every cycle.
module digital_pll_frequency_multiplier #(
	parameter int STEPS_PER_HALF = 16,
	parameter int TIMER_TOP      = 65000
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dpllfm_pkg::IDX_W-1:0]  cfg_index,
	input  logic [dpllfm_pkg::TICK_W-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          zero_cross,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          in_level,
	output logic                          out_level,
	output logic                          dac_step,
	output logic                          phase_active,
	output logic                          direction,
	output logic [dpllfm_pkg::TICK_W-1:0] step_period,
	output logic [dpllfm_pkg::TICK_W-1:0] measured_period,
	output logic [dpllfm_pkg::TICK_W-1:0] phase_width
);
	import dpllfm_pkg::*;

	localparam int LIM_W = $clog2(STEPS_PER_HALF * 255 + 1);
	localparam logic [TICK_W-1:0] TOP = TICK_W'(TIMER_TOP);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_DIV   = 3'b010,
		ST_APPLY = 3'b100
	} state_t;

	function automatic logic [TICK_W-1:0] timer_next(input logic [TICK_W-1:0] v);
		return (v >= TOP) ? '0 : v + 1'b1;
	endfunction

	// configuration
	logic [MULT_W-1:0] mult_q;
	logic [TICK_W-1:0] min_period_q;

	// tick state
	state_t            state_q;
	logic [TICK_W-1:0] in_cnt_q;
	logic [TICK_W-1:0] out_cnt_q;
	logic [TICK_W-1:0] period_q;
	logic [LIM_W-1:0]  step_idx_q;
	logic              in_state_q;
	logic              out_state_q;
	logic              mismatch_flag_q;
	logic [TICK_W-1:0] mismatch_cnt_q;
	logic [TICK_W-1:0] corr_width_q;
	logic [TICK_W-1:0] prev_width_q;
	logic [TICK_W-1:0] corr_q;
	logic              dir_q;
	logic [TICK_W-1:0] last_period_q;

	// output register
	logic              out_valid_q;
	logic              in_level_q;
	logic              out_level_q;
	logic              dac_step_q;
	logic              phase_active_q;
	logic              direction_q;
	logic [TICK_W-1:0] step_period_q;
	logic [TICK_W-1:0] measured_period_q;
	logic [TICK_W-1:0] phase_width_q;

	logic [MULT_W-1:0] mult_eff;
	logic [LIM_W-1:0]  limit;
	logic              in_take;
	logic [TICK_W-1:0] in_cnt_next;
	logic              cross_ok;
	logic              div_start;
	logic [TICK_W-1:0] quotient;
	div_stat_t         div_stat;
	logic [TICK_W:0]   sum_pc;
	logic [TICK_W-1:0] new_period;
	logic              commit;
	logic [TICK_W-1:0] per_eff;
	logic [TICK_W-1:0] out_cnt_inc;
	logic              step;
	logic [LIM_W:0]    idx_inc;
	logic              wrap;
	logic              out_state_next;
	logic [TICK_W-1:0] mc_inc;
	logic              differ;
	logic [TICK_W+RECIP_W-1:0] recip_prod;

	always_comb begin
		mult_eff    = (mult_q == '0) ? MULT_W'(1) : mult_q;
		limit       = LIM_W'(STEPS_PER_HALF) * LIM_W'(mult_eff);
		in_take     = in_valid && in_ready;
		in_cnt_next = timer_next(in_cnt_q);
		cross_ok    = zero_cross && (in_cnt_next >= min_period_q);
		div_start   = in_take && cross_ok;

		sum_pc = {1'b0, quotient} + {1'b0, corr_q};
		if (dir_q) begin
			new_period = sum_pc[TICK_W] ? '1 : sum_pc[TICK_W-1:0];
		end else begin
			new_period = (corr_q > quotient) ? '0 : quotient - corr_q;
		end

		commit         = (state_q == ST_APPLY) && (!out_valid_q || out_ready);
		per_eff        = (period_q == '0) ? TICK_W'(1) : period_q;
		out_cnt_inc    = out_cnt_q + 1'b1;
		step           = (out_cnt_inc >= per_eff);
		idx_inc        = {1'b0, step_idx_q} + 1'b1;
		wrap           = !(idx_inc < {1'b0, limit});
		out_state_next = out_state_q ^ (step && wrap);
		mc_inc         = timer_next(mismatch_cnt_q);
		differ         = in_state_q ^ out_state_next;
		recip_prod     = mc_inc * RECIP_10;
	end

	dpllfm_div #(
		.NUM_W(TICK_W),
		.DEN_W(LIM_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(in_cnt_next),
		.divisor (limit),
		.quotient(quotient),
		.stat    (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q          <= MULT_RESET;
			min_period_q    <= MIN_PERIOD_RESET;
			state_q         <= ST_IDLE;
			in_cnt_q        <= '0;
			out_cnt_q       <= '0;
			period_q        <= TOP;
			step_idx_q      <= '0;
			in_state_q      <= 1'b0;
			out_state_q     <= 1'b0;
			mismatch_flag_q <= 1'b0;
			mismatch_cnt_q  <= '0;
			corr_width_q    <= '0;
			prev_width_q    <= '0;
			corr_q          <= '0;
			dir_q           <= 1'b0;
			last_period_q   <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index == REG_MULTIPLIER) begin
					mult_q <= cfg_data[MULT_W-1:0];
				end else if (cfg_index == REG_MIN_PERIOD) begin
					min_period_q <= cfg_data;
				end
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (cross_ok) begin
							in_cnt_q   <= '0;
							in_state_q <= ~in_state_q;
							state_q    <= ST_DIV;
						end else begin
							in_cnt_q <= in_cnt_next;
							state_q  <= ST_APPLY;
						end
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						period_q      <= new_period;
						last_period_q <= quotient;
						state_q       <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (commit) begin
						out_cnt_q <= step ? '0 : out_cnt_inc;
						if (step) begin
							step_idx_q <= wrap ? '0 : idx_inc[LIM_W-1:0];
						end
						out_state_q    <= out_state_next;
						mismatch_cnt_q <= mc_inc;
						if (differ) begin
							if (!mismatch_flag_q) begin
								mismatch_flag_q <= 1'b1;
								mismatch_cnt_q  <= '0;
							end
						end else if (mismatch_flag_q) begin
							// mismatch ended: width feeds next correction
							mismatch_flag_q <= 1'b0;
							corr_width_q    <= mc_inc;
							prev_width_q    <= mc_inc;
							corr_q          <= TICK_W'(recip_prod[TICK_W+RECIP_W-1:RECIP_SHIFT]);
							if (mc_inc > prev_width_q) begin
								dir_q <= ~dir_q;
							end
						end
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload, loaded with the state after the tick
	always_ff @(posedge clk) begin
		if (commit) begin
			in_level_q        <= in_state_q;
			out_level_q       <= out_state_next;
			dac_step_q        <= step;
			phase_active_q    <= differ;
			step_period_q     <= period_q;
			measured_period_q <= last_period_q;
			if (!differ && mismatch_flag_q) begin
				direction_q   <= dir_q ^ (mc_inc > prev_width_q);
				phase_width_q <= mc_inc;
			end else begin
				direction_q   <= dir_q;
				phase_width_q <= corr_width_q;
			end
		end
	end

	assign cfg_ready       = 1'b1;
	assign in_ready        = (state_q == ST_IDLE);
	assign out_valid       = out_valid_q;
	assign in_level        = in_level_q;
	assign out_level       = out_level_q;
	assign dac_step        = dac_step_q;
	assign phase_active    = phase_active_q;
	assign direction       = direction_q;
	assign step_period     = step_period_q;
	assign measured_period = measured_period_q;
	assign phase_width     = phase_width_q;

	a_div_only_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == ST_DIV)
		else $error("divider busy outside divide state");

	a_timer_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> in_cnt_q == '0)
		else $error("input timer not cleared on accepted crossing");

	a_flag_tracks_xor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> mismatch_flag_q == (in_state_q ^ out_state_q))
		else $error("mismatch flag out of step with levels");

endmodule

>>> rtl/dpllfm_div.sv
// Restoring divider, one quotient bit per cycle.
module dpllfm_div #(
	parameter int NUM_W = 16,
	parameter int DEN_W = 12
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NUM_W-1:0]        dividend,
	input  logic [DEN_W-1:0]        divisor,
	output logic [NUM_W-1:0]        quotient,
	output dpllfm_pkg::div_stat_t   stat
);
	import dpllfm_pkg::*;

	localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0] shifted;
	logic [DEN_W:0] diff;
	logic           ge;

	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		diff    = shifted - {1'b0, den_q};
		ge      = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule
